@@ src/dex_catch_handler_list_parser_macros.svh @@
// Assertion macros for the catch handler list parser checker.
// Included by the checker file only; no other dependencies.
`ifndef DEX_CATCH_HANDLER_LIST_PARSER_MACROS_SVH
`define DEX_CATCH_HANDLER_LIST_PARSER_MACROS_SVH

// Property checked at every rising edge, disabled while reset is held.
`define DCHL_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dchl assertion failed");

// Implication checked at every rising edge, disabled while reset is held.
`define DCHL_ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
    `DCHL_ASSERT_RST(lbl, clk, rst_n, (cond) |-> (prop))

// Next-cycle implication, disabled while reset is held.
`define DCHL_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    `DCHL_ASSERT_RST(lbl, clk, rst_n, (cond) |=> (prop))

`endif

@@ src/dchl_pkg.sv @@
// Shared types and constants of the catch handler list parser.
// No dependencies; used by the front, back and top-level modules.
`default_nettype none

package dchl_pkg;

    localparam int VALUE_W = 32;
    localparam int KIND_W  = 3;
    localparam int NBYTE_W = 3;

    localparam logic [KIND_W-1:0] KIND_LIST_SIZE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HANDLER_SIZE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TYPE_INDEX   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADDRESS      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CATCH_ALL    = 3'd4;

    // A completed LEB128 value as assembled by the front, before any
    // sign extension, with the number of bytes it took (1 to 5).
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [NBYTE_W-1:0] nbytes;
    } t_leb_value;

    typedef struct packed {
        logic [KIND_W-1:0]  field_kind;
        logic [VALUE_W-1:0] field_value;
        logic [VALUE_W-1:0] bytes_used;
        logic               list_done;
    } t_result;

endpackage

`default_nettype wire

@@ src/dchl_fifo.sv @@
// Small register FIFO used for the value queue and the result queue.
// Generic; no package dependency.
`default_nettype none

module dchl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == FULL_CNT);
    assign wr_fire   = i_wr_en && !o_full;
    assign rd_fire   = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

@@ src/dchl_front.sv @@
// Front end: assembles raw LEB128 values one byte per accepted item.
// Uses dchl_pkg for the completed value type.
`default_nettype none

module dchl_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_data_byte,
    output logic                     o_value_valid,
    output dchl_pkg::t_leb_value     o_value
);

    localparam logic [2:0] LAST_BYTE = 3'd4;

    logic [dchl_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic [2:0]                   r_index, n_index;
    logic [dchl_pkg::VALUE_W-1:0] acc_or;
    logic [dchl_pkg::VALUE_W-1:0] low7;
    logic                         done;

    assign low7 = {25'd0, i_data_byte[6:0]};

    always_comb begin
        case (r_index)
            3'd0:    acc_or = r_acc | low7;
            3'd1:    acc_or = r_acc | (low7 << 7);
            3'd2:    acc_or = r_acc | (low7 << 14);
            3'd3:    acc_or = r_acc | (low7 << 21);
            default: acc_or = r_acc | {i_data_byte[3:0], 28'd0};
        endcase
    end

    // The fifth byte always closes a value, whatever its top bit says.
    assign done = (r_index >= LAST_BYTE) || !i_data_byte[7];

    always_comb begin
        n_acc   = r_acc;
        n_index = r_index;
        if (i_accept) begin
            if (done) begin
                n_acc   = '0;
                n_index = '0;
            end else begin
                n_acc   = acc_or;
                n_index = r_index + 1'b1;
            end
        end
    end

    assign o_value_valid = i_accept && done;
    assign o_value.value  = acc_or;
    assign o_value.nbytes = r_index + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_index <= '0;
        end else begin
            r_acc   <= n_acc;
            r_index <= n_index;
        end
    end

endmodule

`default_nettype wire

@@ src/dchl_back.sv @@
// Back end: classifies each completed value by list phase and builds the
// result item. Uses dchl_pkg for kinds, value and result types.
`default_nettype none

module dchl_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_value_valid,
    input  wire dchl_pkg::t_leb_value i_value,
    input  wire logic                 i_res_full,
    output logic                      o_value_take,
    output logic                      o_res_valid,
    output dchl_pkg::t_result         o_res
);

    localparam int W = dchl_pkg::VALUE_W;

    logic [dchl_pkg::KIND_W-1:0] r_phase, n_phase;
    logic [W-1:0]                r_handlers, n_handlers;
    logic [W-1:0]                r_pairs, n_pairs;
    logic                        r_catch_all, n_catch_all;
    logic [W-1:0]                r_byte_count, n_byte_count;

    logic [dchl_pkg::KIND_W-1:0] kind;
    logic [W-1:0]                value;
    logic [W-1:0]                ext_value;
    logic [W:0]                  sum;
    logic [W-1:0]                used;
    logic [W-1:0]                abs_size;
    logic [W-1:0]                pairs_dec;
    logic [W-1:0]                handlers_dec;
    logic                        last;

    assign o_value_take = i_value_valid && !i_res_full;
    assign o_res_valid  = o_value_take;

    assign kind = (r_phase <= dchl_pkg::KIND_CATCH_ALL) ? r_phase
                                                         : dchl_pkg::KIND_LIST_SIZE;

    // Signed sizes that end within four bytes extend from their top data bit.
    always_comb begin
        case (i_value.nbytes)
            3'd1:    ext_value = {{25{i_value.value[6]}},  i_value.value[6:0]};
            3'd2:    ext_value = {{18{i_value.value[13]}}, i_value.value[13:0]};
            3'd3:    ext_value = {{11{i_value.value[20]}}, i_value.value[20:0]};
            3'd4:    ext_value = {{4{i_value.value[27]}},  i_value.value[27:0]};
            default: ext_value = i_value.value;
        endcase
    end

    assign value = (kind == dchl_pkg::KIND_HANDLER_SIZE) ? ext_value : i_value.value;

    assign sum  = {1'b0, r_byte_count} + {{(W + 1 - dchl_pkg::NBYTE_W){1'b0}}, i_value.nbytes};
    assign used = sum[W] ? '1 : sum[W-1:0];

    assign abs_size     = value[W-1] ? (~value + 1'b1) : value;
    assign pairs_dec    = r_pairs - 1'b1;
    assign handlers_dec = r_handlers - 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_handlers   = r_handlers;
        n_pairs      = r_pairs;
        n_catch_all  = r_catch_all;
        last         = 1'b0;
        case (kind)
            dchl_pkg::KIND_HANDLER_SIZE: begin
                n_catch_all = value[W-1] || (value == '0);
                n_pairs     = abs_size;
                n_phase     = (abs_size != '0) ? dchl_pkg::KIND_TYPE_INDEX
                                               : dchl_pkg::KIND_CATCH_ALL;
            end
            dchl_pkg::KIND_TYPE_INDEX: begin
                n_phase = dchl_pkg::KIND_ADDRESS;
            end
            dchl_pkg::KIND_ADDRESS: begin
                n_pairs = pairs_dec;
                if (pairs_dec != '0) begin
                    n_phase = dchl_pkg::KIND_TYPE_INDEX;
                end else if (r_catch_all) begin
                    n_phase = dchl_pkg::KIND_CATCH_ALL;
                end else begin
                    n_handlers = handlers_dec;
                    last       = (handlers_dec == '0);
                    n_phase    = last ? dchl_pkg::KIND_LIST_SIZE
                                      : dchl_pkg::KIND_HANDLER_SIZE;
                end
            end
            dchl_pkg::KIND_CATCH_ALL: begin
                n_catch_all = 1'b0;
                n_handlers  = handlers_dec;
                last        = (handlers_dec == '0);
                n_phase     = last ? dchl_pkg::KIND_LIST_SIZE
                                   : dchl_pkg::KIND_HANDLER_SIZE;
            end
            default: begin
                n_handlers = value;
                last       = (value == '0);
                n_phase    = last ? dchl_pkg::KIND_LIST_SIZE
                                  : dchl_pkg::KIND_HANDLER_SIZE;
            end
        endcase
        n_byte_count = used;
        if (last) begin
            n_byte_count = '0;
            n_pairs      = '0;
            n_catch_all  = 1'b0;
        end
    end

    assign o_res.field_kind  = kind;
    assign o_res.field_value = value;
    assign o_res.bytes_used  = used;
    assign o_res.list_done   = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dchl_pkg::KIND_LIST_SIZE;
            r_handlers   <= '0;
            r_pairs      <= '0;
            r_catch_all  <= 1'b0;
            r_byte_count <= '0;
        end else if (o_value_take) begin
            r_phase      <= n_phase;
            r_handlers   <= n_handlers;
            r_pairs      <= n_pairs;
            r_catch_all  <= n_catch_all;
            r_byte_count <= n_byte_count;
        end
    end

endmodule

`default_nettype wire

@@ src/dex_catch_handler_list_parser.sv @@
// Catch handler list parser: one byte per push, one result per completed
// LEB128 field. Built from dchl_front, dchl_fifo and dchl_back; uses dchl_pkg.
//
// The parser takes one byte of an encoded catch handler list in every cycle
// while full is low, so a stream sustains one byte per clock while results are
// popped. The front end assembles each LEB128 value in the cycle its last byte
// arrives and places it in a value queue of QUEUE_DEPTH entries; the back end
// reads one value per cycle while the result queue has room, tracks the list
// position and writes the finished item into a result queue of OUT_DEPTH
// entries. A field passes through both queues before it reaches the result
// ports, and bytes that do not end a field produce no item. After the field
// flagged o_list_done the parser expects the handler count of a new list.
`default_nettype none

module dex_catch_handler_list_parser #(
    parameter int QUEUE_DEPTH = 2,
    parameter int OUT_DEPTH   = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_field_kind,
    output logic [31:0]      o_field_value,
    output logic [31:0]      o_bytes_used,
    output logic             o_list_done
);

    localparam int VAL_BITS = $bits(dchl_pkg::t_leb_value);
    localparam int RES_BITS = $bits(dchl_pkg::t_result);

    logic                 accept;
    logic                 front_valid;
    dchl_pkg::t_leb_value front_value;
    logic                 q_empty;
    logic [VAL_BITS-1:0]  q_data;
    dchl_pkg::t_leb_value q_value;
    logic                 back_take;
    logic                 res_valid;
    dchl_pkg::t_result    res;
    logic                 res_full;
    logic [RES_BITS-1:0]  out_data;
    dchl_pkg::t_result    out_res;

    assign accept  = push && !full;
    assign q_value = dchl_pkg::t_leb_value'(q_data);
    assign out_res = dchl_pkg::t_result'(out_data);

    dchl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .o_value_valid (front_valid),
        .o_value       (front_value)
    );

    dchl_fifo #(
        .WIDTH (VAL_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_value_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_valid),
        .i_wr_data (front_value),
        .i_rd_en   (back_take),
        .o_rd_data (q_data),
        .o_empty   (q_empty),
        .o_full    (full)
    );

    dchl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (!q_empty),
        .i_value       (q_value),
        .i_res_full    (res_full),
        .o_value_take  (back_take),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    dchl_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_valid),
        .i_wr_data (res),
        .i_rd_en   (pop),
        .o_rd_data (out_data),
        .o_empty   (empty),
        .o_full    (res_full)
    );

    assign o_field_kind  = out_res.field_kind;
    assign o_field_value = out_res.field_value;
    assign o_bytes_used  = out_res.bytes_used;
    assign o_list_done   = out_res.list_done;

endmodule

`default_nettype wire

@@ src/dchl_checker.sv @@
// Port-level checker for the catch handler list parser, bound to the top.
// Depends on dex_catch_handler_list_parser_macros.svh and dchl_pkg.
`default_nettype none
`include "dex_catch_handler_list_parser_macros.svh"

module dchl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  o_field_kind,
    input wire logic [31:0] o_field_value,
    input wire logic [31:0] o_bytes_used,
    input wire logic        o_list_done
);

    // A waiting item stays until it is popped.
    `DCHL_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty)

    // Every field consumes at least one byte of its list.
    `DCHL_ASSERT_IMPLY(a_bytes_nonzero, i_clk, i_rst_n, !empty, o_bytes_used != 32'd0)

    // A list can only end on its count, an address or a catch-all address.
    `DCHL_ASSERT_IMPLY(a_done_kind, i_clk, i_rst_n, !empty && o_list_done, o_field_kind == dchl_pkg::KIND_LIST_SIZE || o_field_kind == dchl_pkg::KIND_ADDRESS || o_field_kind == dchl_pkg::KIND_CATCH_ALL)

    // The handler count ends the list exactly when it is zero.
    `DCHL_ASSERT_IMPLY(a_empty_list, i_clk, i_rst_n, !empty && o_field_kind == dchl_pkg::KIND_LIST_SIZE, o_list_done == (o_field_value == 32'd0))

endmodule

bind dex_catch_handler_list_parser dchl_checker u_dchl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_field_kind  (o_field_kind),
    .o_field_value (o_field_value),
    .o_bytes_used  (o_bytes_used),
    .o_list_done   (o_list_done)
);

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for dex_catch_handler_list_parser: byte stream in, decoded fields out.
// It depends on dchl_pkg for the field kinds and the result struct. A behavioral parser
// inside the testbench predicts every field.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        empty;
    logic        pop         = 1'b0;
    logic [2:0]  o_field_kind;
    logic [31:0] o_field_value;
    logic [31:0] o_bytes_used;
    logic        o_list_done;

    always #5 i_clk = ~i_clk;

    dex_catch_handler_list_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_field_kind  (o_field_kind),
        .o_field_value (o_field_value),
        .o_bytes_used  (o_bytes_used),
        .o_list_done   (o_list_done)
    );

    // Parser state as the stream has been accepted so far.
    logic [2:0]  cur_kind           = dchl_pkg::KIND_LIST_SIZE;
    logic [2:0]  leb_pos            = 3'd0;
    logic [31:0] partial            = 32'd0;
    logic [31:0] handlers_remaining = 32'd0;
    logic [31:0] pairs_remaining    = 32'd0;
    logic        catch_all_due      = 1'b0;
    logic [31:0] list_bytes         = 32'd0;

    dchl_pkg::t_result pending_fields[$];

    int send_gap_max       = 16;
    int recv_gap_max       = 16;
    int result_hold_cycles = 0;
    int bytes_sent         = 0;
    int input_stalls       = 0;
    int fields_checked     = 0;
    int lists_seen         = 0;
    int error_count        = 0;

    function automatic logic close_handler();
        handlers_remaining = handlers_remaining - 32'd1;
        if (handlers_remaining == 32'd0) begin
            cur_kind = dchl_pkg::KIND_LIST_SIZE;
            return 1'b1;
        end
        cur_kind = dchl_pkg::KIND_HANDLER_SIZE;
        return 1'b0;
    endfunction

    // Advances the parser by one accepted byte and queues the field it completes, if any.
    task automatic parse_byte(input logic [7:0] b);
        logic [2:0]        kind;
        logic [31:0]       value;
        logic [31:0]       used;
        logic              last;
        int                nbits;
        dchl_pkg::t_result r;
        kind = (cur_kind <= dchl_pkg::KIND_CATCH_ALL) ? cur_kind : dchl_pkg::KIND_LIST_SIZE;
        last = 1'b0;
        if (list_bytes != 32'hFFFF_FFFF) begin
            list_bytes = list_bytes + 32'd1;
        end
        used = list_bytes;
        if (leb_pos >= 3'd4) begin
            partial |= {b[3:0], 28'd0};
        end else begin
            partial |= 32'(b[6:0]) << (7 * leb_pos);
        end
        if (leb_pos < 3'd4 && b[7]) begin
            leb_pos = leb_pos + 3'd1;
            return;
        end
        value = partial;
        // A handler size shorter than five bytes is sign-extended from its top data bit.
        if (kind == dchl_pkg::KIND_HANDLER_SIZE && leb_pos < 3'd4) begin
            nbits = 7 * (leb_pos + 1);
            if (value[nbits-1]) begin
                value |= ~((32'd1 << nbits) - 32'd1);
            end
        end
        partial = 32'd0;
        leb_pos = 3'd0;
        case (kind)
            dchl_pkg::KIND_HANDLER_SIZE: begin
                catch_all_due   = value[31] || (value == 32'd0);
                pairs_remaining = value[31] ? (32'd0 - value) : value;
                cur_kind = (pairs_remaining != 32'd0) ? dchl_pkg::KIND_TYPE_INDEX
                                                      : dchl_pkg::KIND_CATCH_ALL;
            end
            dchl_pkg::KIND_TYPE_INDEX: begin
                cur_kind = dchl_pkg::KIND_ADDRESS;
            end
            dchl_pkg::KIND_ADDRESS: begin
                pairs_remaining = pairs_remaining - 32'd1;
                if (pairs_remaining != 32'd0) begin
                    cur_kind = dchl_pkg::KIND_TYPE_INDEX;
                end else if (catch_all_due) begin
                    cur_kind = dchl_pkg::KIND_CATCH_ALL;
                end else begin
                    last = close_handler();
                end
            end
            dchl_pkg::KIND_CATCH_ALL: begin
                catch_all_due = 1'b0;
                last = close_handler();
            end
            default: begin
                handlers_remaining = value;
                if (value == 32'd0) begin
                    cur_kind = dchl_pkg::KIND_LIST_SIZE;
                    last = 1'b1;
                end else begin
                    cur_kind = dchl_pkg::KIND_HANDLER_SIZE;
                end
            end
        endcase
        if (last) begin
            list_bytes      = 32'd0;
            pairs_remaining = 32'd0;
            catch_all_due   = 1'b0;
        end
        r.field_kind  = kind;
        r.field_value = value;
        r.bytes_used  = used;
        r.list_done   = last;
        pending_fields.push_back(r);
    endtask

    task automatic report_error(input string msg);
        if (error_count < 10) begin
            $display("%0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    // Offers one item after a random gap and holds it until the parser takes it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        do begin
            @(posedge i_clk);
            if (full) begin
                input_stalls++;
            end
        end while (full);
        parse_byte(b);
        bytes_sent++;
    endtask

    // Encodes v in nbytes LEB128 bytes; a fifth byte carries garbage in its upper nibble.
    task automatic send_value(input logic [31:0] v, input int nbytes, input logic [3:0] garbage);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++) begin
            if (i == 4) begin
                b = {garbage, v[31:28]};
            end else begin
                b = {(i < nbytes - 1), v[7*i +: 7]};
            end
            send_byte(b);
        end
    endtask

    function automatic int min_leb_len(input logic [31:0] v, input logic is_signed);
        int lim;
        for (int n = 1; n <= 4; n++) begin
            lim = 1 << (7 * n - 1);
            if (is_signed) begin
                if ($signed(v) >= -lim && $signed(v) < lim) return n;
            end else if (v < (32'd1 << (7 * n))) begin
                return n;
            end
        end
        return 5;
    endfunction

    // Sends v either minimally encoded or padded with redundant continuation bytes.
    task automatic send_random_value(input logic [31:0] v, input logic is_signed);
        send_value(v, $urandom_range(min_leb_len(v, is_signed), 5), 4'($urandom_range(0, 15)));
    endtask

    function automatic logic [31:0] random_payload();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 127);
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic test_empty_list();
        send_value(32'd0, 1, 4'h0);
        // Five-byte zero count whose last byte has its upper bits set.
        send_value(32'd0, 5, 4'hF);
    endtask

    task automatic test_zero_size();
        send_value(32'd1, 1, 4'h0);
        send_value(32'd0, 1, 4'h0);
        send_value(32'hFFFF_FFFF, 5, 4'hF);
    endtask

    task automatic test_sign_extension();
        send_value(32'd6, 2, 4'h0);
        for (int n = 1; n <= 4; n++) begin
            send_value(32'hFFFF_FFFF, n, 4'h0);
            send_value(32'd127, 1, 4'h0);
            send_value(32'(n), 1, 4'h0);
            send_value(32'd0, 1, 4'h0);
        end
        // A five-byte size is taken as it stands, with no sign extension.
        send_value(32'hFFFF_FFFE, 5, 4'hA);
        repeat (5) send_value(32'($urandom_range(0, 127)), 1, 4'h0);
        // A positive size padded to three bytes has no catch-all and ends the list.
        send_value(32'd2, 3, 4'h0);
        repeat (4) send_value(32'($urandom_range(0, 127)), 1, 4'h0);
    endtask

    task automatic test_input_stall();
        send_gap_max = 0;
        result_hold_cycles = 200;
        send_value(32'd1, 1, 4'h0);
        send_value(32'd10, 1, 4'h0);
        repeat (20) send_value(32'($urandom_range(0, 127)), 1, 4'h0);
        send_gap_max = 16;
    endtask

    // Mostly well-formed lists with random content, with stray bytes mixed in.
    task automatic test_random_stream(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at || cur_kind != dchl_pkg::KIND_LIST_SIZE ||
               leb_pos != 3'd0) begin
            if (cur_kind == dchl_pkg::KIND_LIST_SIZE && leb_pos == 3'd0) begin
                send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            end
            if (leb_pos != 3'd0) begin
                // Close a stray count right away so that it stays small.
                if (cur_kind == dchl_pkg::KIND_LIST_SIZE ||
                    cur_kind == dchl_pkg::KIND_HANDLER_SIZE) begin
                    send_byte(8'h00);
                end else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end else if ($urandom_range(0, 9) == 0) begin
                if (cur_kind == dchl_pkg::KIND_LIST_SIZE ||
                    cur_kind == dchl_pkg::KIND_HANDLER_SIZE) begin
                    send_byte(8'($urandom_range(0, 255)) & 8'h8F);
                end else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                case (cur_kind)
                    dchl_pkg::KIND_LIST_SIZE: begin
                        send_random_value(($urandom_range(0, 15) == 0) ? 32'd0 :
                                          32'($urandom_range(1, 4)), 1'b0);
                    end
                    dchl_pkg::KIND_HANDLER_SIZE: begin
                        send_random_value(32'($urandom_range(0, 6)) - 32'd3, 1'b1);
                    end
                    default: begin
                        send_random_value(random_payload(), 1'b0);
                    end
                endcase
            end
        end
        send_gap_max = 16;
        recv_gap_max = 16;
    endtask

    // A size of -2^31 asks for 2^31 pairs, so this list never ends; it runs last.
    task automatic test_most_negative_size();
        send_value(32'd1, 1, 4'h0);
        send_value(32'h8000_0000, 5, 4'h0);
        repeat (6) send_random_value(random_payload(), 1'b0);
    endtask

    initial begin : result_sink
        int                gap;
        dchl_pkg::t_result got;
        dchl_pkg::t_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            @(negedge i_clk);
            if (gap > 0 || result_hold_cycles > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
                while (result_hold_cycles > 0) begin
                    result_hold_cycles--;
                    @(negedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got.field_kind  = o_field_kind;
            got.field_value = o_field_value;
            got.bytes_used  = o_bytes_used;
            got.list_done   = o_list_done;
            if (o_list_done) begin
                lists_seen++;
            end
            if (pending_fields.size() == 0) begin
                report_error($sformatf("unexpected field kind=%0d value=%h used=%0d done=%0d",
                             got.field_kind, got.field_value, got.bytes_used, got.list_done));
            end else begin
                want = pending_fields.pop_front();
                fields_checked++;
                if (got.field_kind !== want.field_kind || got.field_value !== want.field_value ||
                    got.bytes_used !== want.bytes_used || got.list_done !== want.list_done) begin
                    report_error($sformatf(
                        "field mismatch: kind %0d/%0d value %h/%h used %0d/%0d done %0d/%0d",
                        want.field_kind, got.field_kind, want.field_value, got.field_value,
                        want.bytes_used, got.bytes_used, want.list_done, got.list_done));
                end
            end
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_zero_size();
        test_sign_extension();
        test_input_stall();
        test_random_stream(850);
        test_most_negative_size();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("summary: %0d bytes sent, %0d fields checked, %0d lists closed",
                 bytes_sent, fields_checked, lists_seen);
        $display("summary: input held off for %0d cycles, %0d errors", input_stalls, error_count);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+src
src/dchl_pkg.sv
src/dchl_fifo.sv
src/dchl_front.sv
src/dchl_back.sv
src/dex_catch_handler_list_parser.sv
src/dchl_checker.sv
dv/testbench.sv
